>>> rtl/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// rrfp_pkg
// Shared types and constants of the radar report frame parser.
// ----------------------------------------------------------------------------
package rrfp_pkg;

    localparam int POS_W       = 9;
    localparam int CAP_DEPTH   = 13;
    localparam int CAP_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;
    localparam int OUT_TDATA_W = 128;

    localparam logic [7:0] MAX_LEN_RESET = 8'd64;

    localparam logic [3:0][7:0] HDR_PAT = {8'hF1, 8'hF2, 8'hF3, 8'hF4};
    localparam logic [3:0][7:0] FTR_PAT = {8'hF5, 8'hF6, 8'hF7, 8'hF8};

    localparam logic [7:0] NORMAL_LEN   = 8'd13;
    localparam logic [7:0] NORMAL_B0    = 8'h02;
    localparam logic [7:0] NORMAL_B1    = 8'hAA;
    localparam logic [7:0] NORMAL_B11   = 8'h55;
    localparam logic [7:0] NORMAL_B12   = 8'h00;

    localparam logic [POS_W-1:0] POS_LEN_LO   = 9'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 9'd5;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 9'd6;
    localparam logic [POS_W-1:0] FTR_OFFSET   = 9'd6;
    localparam logic [POS_W-1:0] END_OFFSET   = 9'd9;

    localparam logic [1:0] ST_NORMAL      = 2'd0;
    localparam logic [1:0] ST_BAD_FOOTER  = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE   = 2'd3;

    typedef struct packed {
        logic                 wr_en;
        logic [CAP_IDX_W-1:0] wr_idx;
        logic [7:0]           data;
        logic                 rpt_en;
        logic [1:0]           status;
        logic [15:0]          length;
        logic                 len13;
    } cmd_t;

endpackage

>>> rtl/rrfp_front.sv
// ----------------------------------------------------------------------------
// rrfp_front
// Byte tracker: header hunt, length decode, footer check, and command issue.
// ----------------------------------------------------------------------------
module rrfp_front
    import rrfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       in_ready,
    output logic       push,
    output cmd_t       cmd
);

    logic [7:0]       max_len_reg;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [7:0]       len_lo_reg,    len_lo_next;
    logic [7:0]       len_reg,       len_next;
    logic [POS_W-1:0] end_pos_reg,   end_pos_next;
    logic [POS_W-1:0] ftr_start_reg, ftr_start_next;
    logic             footer_ok_reg, footer_ok_next;

    logic             accept;
    logic [POS_W-1:0] idx;
    logic [1:0]       k;
    logic             ok_now;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign idx      = pos_reg - POS_PAYLOAD;
    assign k        = pos_reg[1:0] - ftr_start_reg[1:0];
    assign ok_now   = footer_ok_reg && !((pos_reg >= ftr_start_reg) && (in_byte != FTR_PAT[k]));

    always_comb
    begin
        pos_next       = pos_reg;
        len_lo_next    = len_lo_reg;
        len_next       = len_reg;
        end_pos_next   = end_pos_reg;
        ftr_start_next = ftr_start_reg;
        footer_ok_next = footer_ok_reg;
        push           = 1'b0;
        cmd            = '0;
        if (accept)
        begin
            if (pos_reg < POS_LEN_LO)
            begin
                if (in_byte == HDR_PAT[pos_reg[1:0]])
                    pos_next = pos_reg + 1'b1;
                else
                    pos_next = (in_byte == HDR_PAT[0]) ? 9'd1 : 9'd0;
            end
            else if (pos_reg == POS_LEN_LO)
            begin
                pos_next    = pos_reg + 1'b1;
                len_lo_next = in_byte;
            end
            else if (pos_reg == POS_LEN_HI)
            begin
                footer_ok_next = 1'b1;
                if ((in_byte != 8'd0) || (len_lo_reg > max_len_reg))
                begin
                    push       = 1'b1;
                    cmd.rpt_en = 1'b1;
                    cmd.status = ST_TOO_LARGE;
                    cmd.length = {in_byte, len_lo_reg};
                    pos_next   = '0;
                end
                else
                begin
                    pos_next       = pos_reg + 1'b1;
                    len_next       = len_lo_reg;
                    end_pos_next   = {1'b0, len_lo_reg} + END_OFFSET;
                    ftr_start_next = {1'b0, len_lo_reg} + FTR_OFFSET;
                end
            end
            else
            begin
                pos_next       = pos_reg + 1'b1;
                footer_ok_next = ok_now;
                if (idx < POS_W'(CAP_DEPTH))
                begin
                    push       = 1'b1;
                    cmd.wr_en  = 1'b1;
                    cmd.wr_idx = idx[CAP_IDX_W-1:0];
                    cmd.data   = in_byte;
                end
                if (pos_reg == end_pos_reg)
                begin
                    push           = 1'b1;
                    cmd.rpt_en     = 1'b1;
                    cmd.status     = ok_now ? ST_NORMAL : ST_BAD_FOOTER;
                    cmd.length     = {8'd0, len_reg};
                    cmd.len13      = (len_reg == NORMAL_LEN);
                    pos_next       = '0;
                    footer_ok_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            pos_reg       <= '0;
            len_lo_reg    <= '0;
            len_reg       <= '0;
            end_pos_reg   <= '0;
            ftr_start_reg <= '0;
            footer_ok_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_wdata;
            pos_reg       <= pos_next;
            len_lo_reg    <= len_lo_next;
            len_reg       <= len_next;
            end_pos_reg   <= end_pos_next;
            ftr_start_reg <= ftr_start_next;
            footer_ok_reg <= footer_ok_next;
        end
    end

endmodule

>>> rtl/rrfp_queue.sv
// ----------------------------------------------------------------------------
// rrfp_queue
// Small command queue between the byte tracker and the report stage.
// ----------------------------------------------------------------------------
module rrfp_queue
    import rrfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg,  count_next;

    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/rrfp_back.sv
// ----------------------------------------------------------------------------
// rrfp_back
// Report stage: payload capture, report decode, frame count, output register.
// ----------------------------------------------------------------------------
module rrfp_back
    import rrfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  cmd_t                   q_cmd,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic [7:0]  cap_reg [CAP_DEPTH];
    logic        valid_reg, valid_next;
    logic [31:0] count_reg, count_next;
    logic [1:0]  status_reg;
    logic [15:0] length_reg;
    logic [7:0]  tstate_reg;
    logic [15:0] mdist_reg;
    logic [7:0]  menergy_reg;
    logic [15:0] sdist_reg;
    logic [7:0]  senergy_reg;
    logic [15:0] ddist_reg;
    logic [31:0] fcount_reg;

    logic        is_normal;
    logic        load;

    assign is_normal = (q_cmd.status == ST_NORMAL) && q_cmd.len13
                       && (cap_reg[0] == NORMAL_B0) && (cap_reg[1] == NORMAL_B1)
                       && (cap_reg[11] == NORMAL_B11) && (cap_reg[12] == NORMAL_B12);
    assign pop  = q_valid && (!q_cmd.rpt_en || !valid_reg || out_ready);
    assign load = pop && q_cmd.rpt_en;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        if (load && is_normal)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_cmd.wr_en && (q_cmd.wr_idx < CAP_IDX_W'(CAP_DEPTH)))
            cap_reg[q_cmd.wr_idx] <= q_cmd.data;
        if (load)
        begin
            length_reg <= q_cmd.length;
            if (is_normal)
            begin
                status_reg  <= ST_NORMAL;
                tstate_reg  <= cap_reg[2];
                mdist_reg   <= {cap_reg[4], cap_reg[3]};
                menergy_reg <= cap_reg[5];
                sdist_reg   <= {cap_reg[7], cap_reg[6]};
                senergy_reg <= cap_reg[8];
                ddist_reg   <= {cap_reg[10], cap_reg[9]};
                fcount_reg  <= count_next;
            end
            else
            begin
                status_reg  <= (q_cmd.status == ST_NORMAL) ? ST_UNSUPPORTED : q_cmd.status;
                tstate_reg  <= '0;
                mdist_reg   <= '0;
                menergy_reg <= '0;
                sdist_reg   <= '0;
                senergy_reg <= '0;
                ddist_reg   <= '0;
                fcount_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {6'd0, fcount_reg, ddist_reg, senergy_reg, sdist_reg,
                        menergy_reg, mdist_reg, tstate_reg, length_reg, status_reg};

endmodule

>>> rtl/radar_report_frame_parser_core.sv
// ----------------------------------------------------------------------------
// radar_report_frame_parser_core
// Parses a received serial byte stream into radar report results.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle. A byte tracker follows the header,
// length, payload and footer and issues commands into a four-entry queue; a
// report stage captures the first 13 payload bytes, decodes the report and
// holds it in an output register. Each result goes through the queue and then
// the output register, and the input stalls only when the output side has
// stalled long enough to fill the queue.
module radar_report_frame_parser_core
    import rrfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // rx_byte[7:0]
    input  logic [7:0]             s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[1:0], frame_len[17:2], target_state[25:18],
    // moving_distance[41:26], mov_energy[49:42], static_distance[65:50],
    // stat_energy[73:66], detection_distance[89:74], frame_count[121:90],
    // zero fill[127:122]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    rrfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .push      (push),
        .cmd       (push_cmd)
    );

    rrfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (q_cmd)
    );

    rrfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // Only a normal report carries decoded fields and a frame count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] != ST_NORMAL)) |->
        (m_axis_tdata[121:18] == '0))
        else $error("non-normal result carries decoded fields");

    // A normal report always comes from a 13-byte payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_NORMAL)) |->
        (m_axis_tdata[17:2] == {8'd0, NORMAL_LEN}))
        else $error("normal report with wrong payload length");

    // A frame-end result always carries a length that fits in one byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tdata[1:0] == ST_BAD_FOOTER)
                        || (m_axis_tdata[1:0] == ST_UNSUPPORTED))) |->
        (m_axis_tdata[17:10] == 8'd0))
        else $error("frame-end result with oversized length");

endmodule

>>> sim/frame_report_checker.sv
// ----------------------------------------------------------------------------
// frame_report_checker
// Watches the byte stream, the limit register and the report stream of the
// radar report frame parser. Every accepted byte is run through a frame
// parser of its own, which tracks the header, length, payload and footer. The
// reports it predicts are queued and compared field by field against the
// reports that the block delivers, in order. The number of failures and the
// number of reports still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module frame_report_checker
    import rrfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output int                     fail_count,
    output int                     reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  fill;
        logic [31:0] frame_count;
        logic [15:0] detection_distance;
        logic [7:0]  stat_energy;
        logic [15:0] static_distance;
        logic [7:0]  mov_energy;
        logic [15:0] moving_distance;
        logic [7:0]  target_state;
        logic [15:0] frame_len;
        logic [1:0]  status;
    } report_t;

    logic [7:0]       limit;
    logic [POS_W-1:0] hunt_pos;
    logic [POS_W-1:0] frame_total;
    logic [7:0]       len_low;
    logic [7:0]       payload_bytes [CAP_DEPTH];
    logic             footer_good;
    logic [31:0]      report_count;
    report_t          reports_q [$];

    function automatic void restart_hunt();
        hunt_pos    = '0;
        frame_total = '0;
        footer_good = 1'b1;
    endfunction

    // Advances the frame parser by one byte; returns 1 when the byte ends a
    // frame or rejects its length, with the report in r.
    function automatic bit parse_byte(input logic [7:0] b, output report_t r);
        int p;
        int len;
        int k;
        r = '0;
        if (hunt_pos < 4)
        begin
            if (b == HDR_PAT[hunt_pos[1:0]])
                hunt_pos = hunt_pos + 1'b1;
            else
                hunt_pos = (b == HDR_PAT[0]) ? 9'd1 : 9'd0;
            return 1'b0;
        end
        p = hunt_pos;
        hunt_pos = hunt_pos + 1'b1;
        if (p == 4)
        begin
            len_low = b;
            return 1'b0;
        end
        if (p == 5)
        begin
            len = {b, len_low};
            if (len > limit)
            begin
                r.status = ST_TOO_LARGE;
                r.frame_len = 16'(len);
                restart_hunt();
                return 1'b1;
            end
            frame_total = POS_W'(10 + len);
            footer_good = 1'b1;
            return 1'b0;
        end
        if (frame_total < 10)
        begin
            restart_hunt();
            return 1'b0;
        end
        if (p - 6 < CAP_DEPTH)
            payload_bytes[4'(p - 6)] = b;
        if (p >= frame_total - 4)
        begin
            k = (p - (frame_total - 4)) % 4;
            if (b != FTR_PAT[k[1:0]])
                footer_good = 1'b0;
        end
        if (p + 1 != frame_total)
            return 1'b0;
        r.frame_len = 16'(frame_total - 10);
        if (!footer_good)
            r.status = ST_BAD_FOOTER;
        else if (frame_total != 10 + NORMAL_LEN || payload_bytes[0] != NORMAL_B0 ||
                 payload_bytes[1] != NORMAL_B1 || payload_bytes[11] != NORMAL_B11 ||
                 payload_bytes[12] != NORMAL_B12)
            r.status = ST_UNSUPPORTED;
        else
        begin
            report_count = report_count + 1'b1;
            r.status             = ST_NORMAL;
            r.target_state       = payload_bytes[2];
            r.moving_distance    = {payload_bytes[4], payload_bytes[3]};
            r.mov_energy         = payload_bytes[5];
            r.static_distance    = {payload_bytes[7], payload_bytes[6]};
            r.stat_energy        = payload_bytes[8];
            r.detection_distance = {payload_bytes[10], payload_bytes[9]};
            r.frame_count        = report_count;
        end
        restart_hunt();
        return 1'b1;
    endfunction

    function automatic string show(report_t r);
        return $sformatf({"status=%0d len=%0d state=%0d mdist=%0d menergy=%0d ",
                          "sdist=%0d senergy=%0d ddist=%0d count=%0d"},
                         r.status, r.frame_len, r.target_state, r.moving_distance,
                         r.mov_energy, r.static_distance, r.stat_energy,
                         r.detection_distance, r.frame_count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        report_t want;
        report_t got;
        if (!rst_n)
        begin
            limit        = MAX_LEN_RESET;
            len_low      = '0;
            report_count = '0;
            foreach (payload_bytes[i])
                payload_bytes[i] = '0;
            restart_hunt();
            reports_q.delete();
            fail_count  = 0;
            reports_due = 0;
        end
        else
        begin
            if (cfg_we)
                limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (parse_byte(s_axis_tdata, want))
                    reports_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (reports_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected report: %s", $time, show(got));
                    fail_count++;
                end
                else
                begin
                    want = reports_q.pop_front();
                    if (got.status !== want.status ||
                        got.frame_len !== want.frame_len ||
                        got.target_state !== want.target_state ||
                        got.moving_distance !== want.moving_distance ||
                        got.mov_energy !== want.mov_energy ||
                        got.static_distance !== want.static_distance ||
                        got.stat_energy !== want.stat_energy ||
                        got.detection_distance !== want.detection_distance ||
                        got.frame_count !== want.frame_count)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: report mismatch", $time);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                        fail_count++;
                    end
                end
            end
            reports_due = reports_q.size();
        end
    end

endmodule

>>> sim/radar_report_frame_parser_core_tb.sv
// ----------------------------------------------------------------------------
// radar_report_frame_parser_core_tb
// Drives byte streams into the radar report frame parser and judges the run.
// A short directed part covers header resynchronization, extreme report
// fields, every report status and the limit extremes. Random phases follow,
// each under its own payload limit, made mostly of well-formed frames with
// random content mixed with damaged frames, oversized lengths and noise.
// Both sides idle in random bursts, and the report side holds off once for a
// long stretch to fill the block. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module radar_report_frame_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rrfp_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [7:0]             cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int reports_due;
    int bytes_sent = 0;
    bit calm = 1'b0;
    bit src_gaps = 1'b1;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always #1 clk = ~clk;

    radar_report_frame_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    frame_report_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .reports_due   (reports_due)
    );

    task automatic send_byte(input logic [7:0] b);
        if (!calm && src_gaps && !(hold_req && !hold_done) && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tdata  <= b;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_length_only(input int len);
        for (int i = 0; i < 4; i++)
            send_byte(HDR_PAT[2'(i)]);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    // A negative fill means random payload; a negative bad position means
    // that nothing is corrupted.
    task automatic send_frame(input int len, input bit shaped, input int fill,
                              input int bad_ftr, input int bad_mark);
        logic [7:0] b;
        send_length_only(len);
        for (int i = 0; i < len; i++)
        begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (shaped)
            begin
                case (i)
                    0:       b = NORMAL_B0;
                    1:       b = NORMAL_B1;
                    11:      b = NORMAL_B11;
                    12:      b = NORMAL_B12;
                    default: ;
                endcase
            end
            if (i == bad_mark)
                b ^= 8'($urandom_range(1, 255));
            send_byte(b);
        end
        for (int i = 0; i < 4; i++)
        begin
            b = FTR_PAT[2'(i)];
            if (i == bad_ftr)
                b ^= 8'($urandom_range(1, 255));
            send_byte(b);
        end
    endtask

    task automatic write_limit(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        while (reports_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int phase_end;
        int pick;
        int len;
        int hi;
        int mark;
        int prefix;
        logic [7:0] lim;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        write_limit(NORMAL_LEN);
        send_byte(8'h00);
        send_byte(HDR_PAT[0]);
        send_byte(HDR_PAT[1]);
        send_byte(8'h00);
        send_byte(HDR_PAT[0]);
        send_frame(13, 1'b1, 8'hFF, -1, -1);
        send_frame(13, 1'b1, 8'h00, -1, -1);
        send_length_only(14);
        send_length_only(16'hFFFF);
        send_frame(13, 1'b1, -1, 3, -1);
        send_frame(13, 1'b1, -1, -1, 12);
        write_limit(8'd0);
        send_frame(0, 1'b0, -1, -1, -1);
        send_length_only(1);
        write_limit(8'd255);
        send_frame(255, 1'b0, -1, -1, -1);
        send_frame(255, 1'b0, -1, 0, -1);
        send_length_only(256);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       lim = MAX_LEN_RESET;
                1:       lim = NORMAL_LEN;
                2:       lim = 8'd255;
                3:       lim = 8'd0;
                default: lim = 8'($urandom_range(1, 254));
            endcase
            write_limit(lim);
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == 5)
                calm = 1'b1;
            phase_end = bytes_sent + 65;
            while (bytes_sent < phase_end)
            begin
                src_gaps = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    mark = $urandom_range(0, 3);
                    mark = (mark < 2) ? mark : mark + 9;
                    send_frame(13, 1'b1, -1,
                               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : -1,
                               ($urandom_range(0, 7) == 0) ? mark : -1);
                end
                else if (pick < 70)
                begin
                    hi = (lim < 16) ? lim : 16;
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lim)
                                                       : $urandom_range(0, hi);
                    send_frame(len, 1'b0, -1,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : -1, -1);
                end
                else if (pick < 80)
                begin
                    if (lim == 8'd255 || $urandom_range(0, 2) == 0)
                        len = $urandom_range(256, 65535);
                    else if ($urandom_range(0, 1) == 0)
                        len = lim + 1;
                    else
                        len = $urandom_range(lim + 1, 255);
                    send_length_only(len);
                end
                else
                begin
                    prefix = $urandom_range(0, 3);
                    for (int i = 0; i < prefix; i++)
                        send_byte(HDR_PAT[2'(i)]);
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (reports_due != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : report_sink
        int mode_left;
        bit busy_mode;
        m_axis_tready = 1'b0;
        mode_left = 0;
        busy_mode = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                busy_mode = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(20, 60);
            end
            mode_left--;
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                for (int c = 0; c < 80; c++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && busy_mode && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/rrfp_pkg.sv
rtl/rrfp_front.sv
rtl/rrfp_queue.sv
rtl/rrfp_back.sv
rtl/radar_report_frame_parser_core.sv
sim/frame_report_checker.sv
sim/radar_report_frame_parser_core_tb.sv
